// ----- rtl/qpht_pkg.sv -----
// Shared constants, codes and types of the quadratic-probe hash table.
`default_nettype none

package qpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 11;
    localparam int PROBE_CAP   = 1024;
    localparam int TOTAL_W     = 32;
    localparam int ENTRY_W     = 1 + KEY_BITS + VALUE_BITS;

    typedef enum logic [1:0] {
        STS_MATCH = 2'd0,
        STS_EMPTY = 2'd1,
        STS_LIMIT = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_PROBES = 2'd1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic                  occupied;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // Control from the sequencer to the probe address stepper
    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctl;

endpackage

`default_nettype wire

// ----- rtl/qpht_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/qpht_step.sv -----
// Probe address stepper: home + i*i mod n by running differences.
`default_nettype none

module qpht_step import qpht_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_step_ctl        i_ctl,
    input  wire logic [ADDR_W-1:0] i_home,
    input  wire logic [CFG_W-1:0] i_size,
    output logic      [ADDR_W-1:0] o_pos,
    output logic      [ADDR_W-1:0] o_next_pos,
    output logic      [CNT_W-1:0] o_count
);

    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W:0]   pos_sum;
    logic [ADDR_W:0]   step_a, step_b, step_c;

    // Next slot: pos and step both stay below n, so one subtract folds it
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (pos_sum >= (ADDR_W+1)'(i_size)) begin
            pos_sum = pos_sum - (ADDR_W+1)'(i_size);
        end
        o_next_pos = pos_sum[ADDR_W-1:0];
    end

    // Odd difference grows by two; n of one needs a second fold
    always_comb begin
        step_a = {1'b0, r_step} + (ADDR_W+1)'(2);
        step_b = (step_a >= (ADDR_W+1)'(i_size)) ? step_a - (ADDR_W+1)'(i_size) : step_a;
        step_c = (step_b >= (ADDR_W+1)'(i_size)) ? step_b - (ADDR_W+1)'(i_size) : step_b;
    end

    always_comb begin
        n_pos   = r_pos;
        n_step  = r_step;
        n_count = r_count;
        if (i_ctl.load) begin
            n_pos   = i_home;
            n_step  = (i_size == CFG_W'(1)) ? ADDR_W'(0) : ADDR_W'(1);
            n_count = '0;
        end else if (i_ctl.advance) begin
            n_pos   = o_next_pos;
            n_step  = step_c[ADDR_W-1:0];
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_count <= n_count;
    end

    assign o_pos   = r_pos;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- rtl/quadratic_probe_hash_table_unit.sv -----
// Top level of the quadratic-probe hash table: sequencer, slot store and results.
// Slots read per item: the collisions plus one, or the collisions alone when the probe
//   limit ends the item. A new item is taken only once the last one is finished.
//   A home index out of range is answered in the cycle after its transfer, without probing.
// Reset: synchronous, active low; a clearing pass then empties all 1024 slots with busy
//   held high. Configuration writes are taken at any time.
// The receiver cannot stall: o_done is high for exactly one cycle per item.
`default_nettype none

module quadratic_probe_hash_table_unit import qpht_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_operation,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [ADDR_W-1:0]     i_home_index,
    input  wire logic [VALUE_BITS-1:0] i_value,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // result channel
    output logic                       o_done,
    output logic [ADDR_W-1:0]          o_slot_index,
    output logic [1:0]                 o_status,
    output logic [VALUE_BITS-1:0]      o_stored_value,
    output logic [CNT_W-1:0]           o_probe_count,
    output logic [TOTAL_W-1:0]         o_total_collisions
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_table_size, r_max_probes;
    logic [CFG_W-1:0]      eff_size, eff_limit;

    // Item held for the whole probe sequence
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    logic [ADDR_W-1:0]     r_clr_addr, n_clr_addr;

    // Result registers and running total
    logic                  r_done, n_done;
    logic [ADDR_W-1:0]     r_slot, n_slot;
    t_status               r_status, n_status;
    logic [VALUE_BITS-1:0] r_stored, n_stored;
    logic [CNT_W-1:0]      r_probes, n_probes;
    logic [TOTAL_W-1:0]    r_total, n_total;

    // RAM ports
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    t_entry                mem_wdata, mem_rdata;
    logic [ENTRY_W-1:0]    mem_rdata_raw;

    t_step_ctl             step_ctl;
    logic [ADDR_W-1:0]     pos, next_pos;
    logic [CNT_W-1:0]      count, count_inc;

    logic                  accept, out_of_range;
    logic                  hit, empty, at_limit, finish;
    logic [TOTAL_W:0]      total_sum;

    assign accept       = start && !busy;
    assign o_cfg_ready  = 1'b1;
    assign out_of_range = {1'b0, i_home_index} >= eff_size;

    // Zero reads as one, anything past the store or cap is clipped
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = CFG_W'(1);
        end else if (r_table_size > CFG_W'(TABLE_DEPTH)) begin
            eff_size = CFG_W'(TABLE_DEPTH);
        end else begin
            eff_size = r_table_size;
        end
        if (r_max_probes == '0) begin
            eff_limit = CFG_W'(1);
        end else if (r_max_probes > CFG_W'(PROBE_CAP)) begin
            eff_limit = CFG_W'(PROBE_CAP);
        end else begin
            eff_limit = r_max_probes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= CFG_W'(1021);
            r_max_probes <= CFG_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                CFG_MAX_PROBES: r_max_probes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata_raw)
    );

    assign mem_rdata = t_entry'(mem_rdata_raw);

    qpht_step u_step (
        .i_clk      (i_clk),
        .i_ctl      (step_ctl),
        .i_home     (i_home_index),
        .i_size     (eff_size),
        .o_pos      (pos),
        .o_next_pos (next_pos),
        .o_count    (count)
    );

    // Judge the slot read in the previous cycle
    assign count_inc = count + CNT_W'(1);
    assign empty     = !mem_rdata.occupied;
    assign hit       = mem_rdata.occupied && (mem_rdata.key == r_key);
    assign at_limit  = !empty && !hit && (count_inc >= eff_limit);
    assign finish    = empty || hit || at_limit;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && !out_of_range) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs of the sequencer: RAM access, stepper control, result and total
    always_comb begin
        busy       = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = pos;
        mem_wdata  = '{occupied: 1'b1, key: r_key, value: r_value};
        mem_raddr  = i_home_index;
        step_ctl   = '{load: 1'b0, advance: 1'b0};
        n_clr_addr = r_clr_addr;
        n_done     = 1'b0;
        n_slot     = r_slot;
        n_status   = r_status;
        n_stored   = r_stored;
        n_probes   = r_probes;
        n_total    = r_total;
        total_sum  = {1'b0, r_total};
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                busy          = 1'b0;
                step_ctl.load = accept;
                // Out of range home: answer at once, write nothing and keep the total
                if (accept && out_of_range) begin
                    n_done   = 1'b1;
                    n_slot   = i_home_index;
                    n_status = STS_RANGE;
                    n_stored = '0;
                    n_probes = '0;
                end
            end
            S_PROBE: begin
                mem_raddr = next_pos;
                if (finish) begin
                    n_done   = 1'b1;
                    n_slot   = pos;
                    n_stored = '0;
                    if (at_limit) begin
                        n_status = STS_LIMIT;
                        n_probes = count_inc;
                    end else begin
                        n_status = hit ? STS_MATCH : STS_EMPTY;
                        n_probes = count;
                        if (r_op == OP_INSERT) begin
                            mem_we   = 1'b1;
                            n_stored = r_value;
                        end else if (hit) begin
                            n_stored = mem_rdata.value;
                        end
                    end
                    // Saturate the running total
                    total_sum = {1'b0, r_total} + (TOTAL_W+1)'(n_probes);
                    n_total   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                end else begin
                    step_ctl.advance = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_total    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
            r_total    <= n_total;
        end
    end

    // Payload: hold the item and the last result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= i_key[KEY_BITS-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
        end
        r_slot   <= n_slot;
        r_status <= n_status;
        r_stored <= n_stored;
        r_probes <= n_probes;
    end

    assign o_done             = r_done;
    assign o_slot_index       = r_slot;
    assign o_status           = r_status;
    assign o_stored_value     = r_stored;
    assign o_probe_count      = r_probes;
    assign o_total_collisions = r_total;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the quadratic-probe hash table: directed table, then random phases.
`default_nettype none

module tb import qpht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // One command as the sender drives it, one result as the block reports it
    typedef struct packed {
        logic                  op;
        logic [KEY_BITS-1:0]   key;
        logic [ADDR_W-1:0]     home;
        logic [VALUE_BITS-1:0] value;
    } t_command;

    typedef struct packed {
        logic [ADDR_W-1:0]     slot;
        t_status               status;
        logic [VALUE_BITS-1:0] stored;
        logic [CNT_W-1:0]      probes;
        logic [TOTAL_W-1:0]    total;
    } t_outcome;

    // A row of the directed table: either a register write or a command, the latter
    // optionally carrying a hand-written expectation
    typedef struct {
        bit         is_reg;
        logic [1:0] reg_idx;
        logic [CFG_W-1:0] reg_data;
        t_command   cmd;
        bit         typed;
        t_outcome   want;
    } t_row;

    // A random phase: register setting, command count, size of the key pool, idling off
    typedef struct {
        int unsigned size;
        int unsigned probes;
        int unsigned count;
        int unsigned pool;
        bit          calm;
    } t_phase;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  i_operation  = OP_LOOKUP;
    logic [KEY_BITS-1:0]   i_key        = '0;
    logic [ADDR_W-1:0]     i_home_index = '0;
    logic [VALUE_BITS-1:0] i_value      = '0;
    logic                  i_cfg_valid  = 1'b0;
    logic [1:0]            i_cfg_index  = CFG_TABLE_SIZE;
    logic [CFG_W-1:0]      i_cfg_data   = '0;
    logic                  busy;
    logic                  o_cfg_ready;
    logic                  o_done;
    logic [ADDR_W-1:0]     o_slot_index;
    logic [1:0]            o_status;
    logic [VALUE_BITS-1:0] o_stored_value;
    logic [CNT_W-1:0]      o_probe_count;
    logic [TOTAL_W-1:0]    o_total_collisions;

    quadratic_probe_hash_table_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_key              (i_key),
        .i_home_index       (i_home_index),
        .i_value            (i_value),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_slot_index       (o_slot_index),
        .o_status           (o_status),
        .o_stored_value     (o_stored_value),
        .o_probe_count      (o_probe_count),
        .o_total_collisions (o_total_collisions)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the table: occupancy, keys, values, running total and both registers
    bit                    slot_used  [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   slot_key   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] slot_data  [TABLE_DEPTH];
    logic [TOTAL_W-1:0]    collision_sum = '0;
    logic [CFG_W-1:0]      size_reg      = 11'd1021;
    logic [CFG_W-1:0]      limit_reg     = 11'd1024;

    t_outcome pending_outcomes[$];
    int       errors      = 0;
    int       lookups     = 0;
    int       inserts     = 0;
    int       settings    = 1;
    int       status_seen [4];
    int       deepest     = 0;

    // Zero reads as one slot, anything past the store as the whole store
    function automatic int unsigned active_slots();
        if (size_reg == 0) return 1;
        if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
        return size_reg;
    endfunction

    // Walk the probe sequence of one command, update the shadow table and
    // return what the block must report for it
    function automatic t_outcome probe_table(input t_command c);
        int unsigned n;
        int unsigned lim;
        int unsigned pos;
        int unsigned hits;
        logic [TOTAL_W:0] sum;
        t_outcome r;
        n   = active_slots();
        lim = (limit_reg == 0) ? 1 : (limit_reg > PROBE_CAP) ? PROBE_CAP : limit_reg;
        r   = '0;
        if (c.home >= n) begin
            // out of range: nothing probed, nothing written, total held
            r.slot   = c.home;
            r.status = STS_RANGE;
            r.total  = collision_sum;
            return r;
        end
        pos  = c.home;
        hits = 0;
        forever begin
            if (!slot_used[pos]) begin
                r.status = STS_EMPTY;
                break;
            end
            if (slot_key[pos] == c.key) begin
                r.status = STS_MATCH;
                break;
            end
            hits++;
            if (hits >= lim) begin
                // stop on the last slot that collided
                r.status = STS_LIMIT;
                break;
            end
            pos = (c.home + hits * hits) % n;
        end
        if (r.status != STS_LIMIT) begin
            if (c.op == OP_INSERT) begin
                slot_key[pos]  = c.key;
                slot_data[pos] = c.value;
                slot_used[pos] = 1'b1;
                r.stored       = c.value;
            end else if (r.status == STS_MATCH) begin
                r.stored = slot_data[pos];
            end
        end
        sum           = {1'b0, collision_sum} + hits;
        collision_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        r.slot        = ADDR_W'(pos);
        r.probes      = CNT_W'(hits);
        r.total       = collision_sum;
        return r;
    endfunction

    // Home index as an external hash would give it, for the current table size
    function automatic logic [ADDR_W-1:0] spread(input logic [KEY_BITS-1:0] k);
        logic [31:0] h;
        h = k[31:0] ^ k[63:32];
        h = h ^ (h >> 13) ^ (h << 5);
        return ADDR_W'(h % active_slots());
    endfunction

    // Drive one command and hold it until the transfer; start stays high so the
    // caller can chain the next command in the same step
    task automatic send(input t_command c, input bit typed, input t_outcome want);
        t_outcome guess;
        start        <= 1'b1;
        i_operation  <= c.op;
        i_key        <= c.key;
        i_home_index <= c.home;
        i_value      <= c.value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        guess = probe_table(c);
        pending_outcomes.push_back(typed ? want : guess);
        if (c.op == OP_INSERT) inserts++;
        else lookups++;
    endtask

    // Drop start and idle for as long as the caller asks
    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every result is in, then give the block its tail latency
    task automatic settle();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register with the block idle and mirror it in the shadow
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TABLE_SIZE) size_reg = data;
        else limit_reg = data;
        settings++;
    endtask

    function automatic t_row cmd_row(input logic op, input logic [KEY_BITS-1:0] key,
                                     input int unsigned home,
                                     input logic [VALUE_BITS-1:0] value);
        t_row r;
        r         = '{default: '0};
        r.cmd     = '{op, key, ADDR_W'(home), value};
        return r;
    endfunction

    function automatic t_row typed_row(input logic op, input logic [KEY_BITS-1:0] key,
                                       input int unsigned home,
                                       input logic [VALUE_BITS-1:0] value,
                                       input t_outcome want);
        t_row r;
        r       = cmd_row(op, key, home, value);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [1:0] idx, input int unsigned data);
        t_row r;
        r          = '{default: '0};
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = CFG_W'(data);
        return r;
    endfunction

    // Compare each strobed result against the oldest expectation, field by field
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with nothing expected: slot_index %0d status %0d",
                       o_slot_index, o_status);
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                status_seen[want.status]++;
                if (want.probes > deepest) deepest = want.probes;
                if (o_slot_index !== want.slot) begin
                    $error("slot_index expected %0d actual %0d", want.slot, o_slot_index);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    errors++;
                end
                if (o_stored_value !== want.stored) begin
                    $error("stored_value expected %h actual %h", want.stored, o_stored_value);
                    errors++;
                end
                if (o_probe_count !== want.probes) begin
                    $error("probe_count expected %0d actual %0d", want.probes, o_probe_count);
                    errors++;
                end
                if (o_total_collisions !== want.total) begin
                    $error("total_collisions expected %0d actual %0d",
                           want.total, o_total_collisions);
                    errors++;
                end
            end
        end
    end

    // Stimulus: directed table first, then random phases over several settings
    initial begin
        t_row     plan[$];
        t_phase   phases[$];
        t_command c;
        logic [KEY_BITS-1:0] key_pool[$];
        logic [KEY_BITS-1:0] k;

        // Directed rows; expectations typed in only where they are plain to see
        plan.push_back(typed_row(OP_LOOKUP, 64'd0, 0, 32'd0,
                                 t_outcome'{10'd0, STS_EMPTY, 32'd0, 11'd0, 32'd0}));
        plan.push_back(typed_row(OP_INSERT, 64'd0, 0, 32'hFFFF_FFFF,
                                 t_outcome'{10'd0, STS_EMPTY, 32'hFFFF_FFFF, 11'd0, 32'd0}));
        plan.push_back(typed_row(OP_LOOKUP, 64'd0, 0, 32'd0,
                                 t_outcome'{10'd0, STS_MATCH, 32'hFFFF_FFFF, 11'd0, 32'd0}));
        plan.push_back(cmd_row(OP_INSERT, '1, 0, 32'd0));
        plan.push_back(typed_row(OP_LOOKUP, '1, 1023, 32'd0,
                                 t_outcome'{10'd1023, STS_RANGE, 32'd0, 11'd0, 32'd1}));
        plan.push_back(typed_row(OP_INSERT, 64'd3, 1021, 32'd5,
                                 t_outcome'{10'd1021, STS_RANGE, 32'd0, 11'd0, 32'd1}));
        plan.push_back(cmd_row(OP_INSERT, 64'd5, 1020, 32'hA5A5_A5A5));
        plan.push_back(cmd_row(OP_INSERT, 64'd0, 0, 32'h1234_5678));
        plan.push_back(cmd_row(OP_LOOKUP, 64'h8000_0000_0000_0001, 512, 32'hFFFF_FFFF));
        // Both registers at zero: a single slot and a single collision allowed
        plan.push_back(reg_row(CFG_TABLE_SIZE, 0));
        plan.push_back(reg_row(CFG_MAX_PROBES, 0));
        plan.push_back(typed_row(OP_LOOKUP, 64'd0, 1, 32'd0,
                                 t_outcome'{10'd1, STS_RANGE, 32'd0, 11'd0, 32'd1}));
        plan.push_back(cmd_row(OP_LOOKUP, 64'd0, 0, 32'd0));
        plan.push_back(cmd_row(OP_INSERT, 64'd7, 0, 32'd1));
        // Probe limit above the cap: one slot collides for the full 1024 steps
        plan.push_back(reg_row(CFG_MAX_PROBES, 2047));
        plan.push_back(cmd_row(OP_LOOKUP, 64'd9, 0, 32'd0));
        // Table size above the store; old entries must still be found
        plan.push_back(reg_row(CFG_TABLE_SIZE, 2047));
        plan.push_back(reg_row(CFG_MAX_PROBES, 1024));
        plan.push_back(cmd_row(OP_INSERT, 64'h0123_4567_89AB_CDEF, 1023, 32'h5555_AAAA));
        plan.push_back(cmd_row(OP_LOOKUP, 64'd5, 1020, 32'd0));
        plan.push_back(cmd_row(OP_LOOKUP, '1, 1, 32'd0));
        // Tiny table, short limit: crowd one home until the limit trips
        plan.push_back(reg_row(CFG_TABLE_SIZE, 5));
        plan.push_back(reg_row(CFG_MAX_PROBES, 3));
        for (int i = 0; i < 5; i++)
            plan.push_back(cmd_row(OP_INSERT, 64'd100 + i, 2, 32'hC000_0000 + i));
        plan.push_back(cmd_row(OP_LOOKUP, 64'd104, 2, 32'd0));
        plan.push_back(cmd_row(OP_LOOKUP, 64'd0, 4, 32'd0));
        plan.push_back(cmd_row(OP_INSERT, 64'd1, 3, 32'd0));

        // Random phases: size, limit, commands, key pool, idling off
        phases.push_back('{1021, 1024, 150, 120, 1'b0});
        phases.push_back('{13,   4,    120, 10,  1'b0});
        phases.push_back('{1,    1,    40,  3,   1'b0});
        phases.push_back('{64,   16,   150, 40,  1'b1});
        phases.push_back('{0,    2047, 8,   2,   1'b0});
        phases.push_back('{31,   1024, 100, 20,  1'b0});
        phases.push_back('{1024, 1024, 150, 300, 1'b0});
        phases.push_back('{2,    1,    50,  4,   1'b0});
        phases.push_back('{257,  64,   160, 150, 1'b0});

        // Hold reset, then release it; the block then clears its store with busy high
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                if ($urandom_range(99) < 14) pause($urandom_range(1, 5));
                send(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end

        foreach (phases[p]) begin
            write_reg(CFG_TABLE_SIZE, CFG_W'(phases[p].size));
            write_reg(CFG_MAX_PROBES, CFG_W'(phases[p].probes));
            // Fresh keys each phase; some differ from a neighbour in one bit only
            key_pool.delete();
            for (int j = 0; j < phases[p].pool; j++) begin
                if (j > 0 && $urandom_range(7) == 0)
                    k = key_pool[j-1] ^ (64'd1 << $urandom_range(63));
                else
                    k = {$urandom, $urandom};
                key_pool.push_back(k);
            end
            for (int j = 0; j < phases[p].count; j++) begin
                if (!phases[p].calm) begin
                    if ($urandom_range(59) == 0) settle();
                    else if ($urandom_range(99) < 14) pause($urandom_range(1, 6));
                end
                // Mostly pooled keys at their hashed home; the rest is noise
                if ($urandom_range(99) < 85) begin
                    c.key  = key_pool[$urandom_range(key_pool.size() - 1)];
                    c.home = spread(c.key);
                end else begin
                    c.key  = {$urandom, $urandom};
                    c.home = ADDR_W'($urandom_range(TABLE_DEPTH - 1));
                end
                c.op    = $urandom_range(1) ? OP_INSERT : OP_LOOKUP;
                c.value = $urandom;
                send(c, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d lookups and %0d inserts over %0d register settings, longest probe %0d.",
                 lookups, inserts, settings, deepest);
        $display("Outcomes: %0d matched, %0d reached empty, %0d hit the limit, %0d out of range.",
                 status_seen[STS_MATCH], status_seen[STS_EMPTY],
                 status_seen[STS_LIMIT], status_seen[STS_RANGE]);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
